>>> hw/rtl/teq_pkg.sv
// Shared types and constants for the timed event queue.
`timescale 1ns / 1ps
package teq_pkg;

    localparam int TIME_W     = 32;
    localparam int DELAY_W    = 31;
    localparam int TAG_W      = 16;
    localparam int HANDLE_W   = 4;
    localparam int HANDLE_CNT = 16;
    localparam int CMD_W      = 2;
    localparam int STAT_W     = 3;

    // Input beat: tuser = cmd; tdata = event_time, delay, now, tag, handle.
    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 56;

    localparam logic [CMD_W-1:0] CMD_INS_ABS = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INS_REL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CANCEL  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_POLL    = 2'd3;

    localparam logic [STAT_W-1:0] STAT_INSERTED    = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL        = 3'd1;
    localparam logic [STAT_W-1:0] STAT_CANCELLED   = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_FIRED       = 3'd4;
    localparam logic [STAT_W-1:0] STAT_NOTHING_DUE = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    typedef struct packed {
        logic capture;   // latch the incoming command
        logic execute;   // apply it to the cell chain, load the result
    } t_dp_cmd;

endpackage

>>> hw/rtl/teq_ctrl.sv
// Controller state machine of the timed event queue.
`timescale 1ns / 1ps
module teq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_ready,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output teq_pkg::t_dp_cmd o_dp_cmd
);
    import teq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready       = 1'b0;
        o_out_valid      = 1'b0;
        o_dp_cmd.capture = 1'b0;
        o_dp_cmd.execute = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready       = i_rst_n;
                o_dp_cmd.capture = i_in_valid & i_rst_n;
            end
            S_EXEC: begin
                o_dp_cmd.execute = 1'b1;
            end
            S_RESP: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> hw/rtl/teq_dp.sv
// Datapath of the timed event queue: sorted shift cell chain and result register.
`timescale 1ns / 1ps
module teq_dp #(
    parameter int DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  teq_pkg::t_dp_cmd              i_dp_cmd,
    input  logic [teq_pkg::CMD_W-1:0]     i_cmd,
    input  logic [teq_pkg::TIME_W-1:0]    i_event_time,
    input  logic [teq_pkg::DELAY_W-1:0]   i_delay,
    input  logic [teq_pkg::TIME_W-1:0]    i_now,
    input  logic [teq_pkg::TAG_W-1:0]     i_tag,
    input  logic [teq_pkg::HANDLE_W-1:0]  i_handle,
    output logic [teq_pkg::STAT_W-1:0]    o_status,
    output logic [teq_pkg::HANDLE_W-1:0]  o_result_handle,
    output logic [teq_pkg::TAG_W-1:0]     o_result_tag,
    output logic [teq_pkg::TIME_W-1:0]    o_fire_time
);
    import teq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    // latched command
    logic [CMD_W-1:0]    r_op;
    logic [TIME_W-1:0]   r_time;
    logic [TIME_W-1:0]   r_now;
    logic [TAG_W-1:0]    r_tag;
    logic [HANDLE_W-1:0] r_handle;

    // cell chain, cell 0 is the head
    logic [TIME_W-1:0]   r_cell_time [DEPTH];
    logic [TAG_W-1:0]    r_cell_tag  [DEPTH];
    logic [HANDLE_W-1:0] r_cell_hdl  [DEPTH];
    logic [CNT_W-1:0]    r_count;
    logic [HANDLE_CNT-1:0] r_in_use;

    // result register
    logic [STAT_W-1:0]   r_status;
    logic [HANDLE_W-1:0] r_res_handle;
    logic [TAG_W-1:0]    r_res_tag;
    logic [TIME_W-1:0]   r_res_time;

    logic [DEPTH-1:0]    gt;      // live cell strictly earlier than the new time
    logic [DEPTH-1:0]    match;   // live cell holding the handle to cancel
    logic [DEPTH-1:0]    after;   // at or past the cancelled cell
    logic [HANDLE_W-1:0] free_hdl;
    logic                full;
    logic                found;
    logic                due;
    logic                do_ins;

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.capture) begin
            r_op     <= i_cmd;
            r_now    <= i_now;
            r_tag    <= i_tag;
            r_handle <= i_handle;
            if (i_cmd == CMD_INS_REL) begin
                r_time <= i_now + {1'b0, i_delay};
            end else begin
                r_time <= i_event_time;
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_flag
            logic live;
            assign live      = r_count > CNT_W'(gi);
            assign gt[gi]    = live && (r_time > r_cell_time[gi]);
            assign match[gi] = live && (r_cell_hdl[gi] == r_handle);
            if (gi == 0) begin : g_head
                assign after[gi] = match[gi];
            end else begin : g_rest
                assign after[gi] = after[gi-1] | match[gi];
            end
        end
    endgenerate

    always_comb begin
        free_hdl = '0;
        for (int j = HANDLE_CNT - 1; j >= 0; j--) begin
            if (!r_in_use[j]) begin
                free_hdl = HANDLE_W'(j);
            end
        end
    end

    assign full   = (r_count == CNT_W'(DEPTH)) || (&r_in_use);
    assign found  = |match;
    assign due    = (r_count != '0) && !(r_cell_time[0] > r_now);
    assign do_ins = ((r_op == CMD_INS_ABS) || (r_op == CMD_INS_REL)) && !full;

    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic                at_pos;
            logic [TIME_W-1:0]   p_time;
            logic [TAG_W-1:0]    p_tag;
            logic [HANDLE_W-1:0] p_hdl;
            logic [TIME_W-1:0]   s_time;
            logic [TAG_W-1:0]    s_tag;
            logic [HANDLE_W-1:0] s_hdl;

            if (gi == 0) begin : g_first
                assign at_pos = !gt[gi];
                assign p_time = r_time;
                assign p_tag  = r_tag;
                assign p_hdl  = free_hdl;
            end else begin : g_mid
                assign at_pos = !gt[gi] && gt[gi-1];
                assign p_time = r_cell_time[gi-1];
                assign p_tag  = r_cell_tag[gi-1];
                assign p_hdl  = r_cell_hdl[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_last
                assign s_time = r_cell_time[gi];
                assign s_tag  = r_cell_tag[gi];
                assign s_hdl  = r_cell_hdl[gi];
            end else begin : g_inner
                assign s_time = r_cell_time[gi+1];
                assign s_tag  = r_cell_tag[gi+1];
                assign s_hdl  = r_cell_hdl[gi+1];
            end

            always_ff @(posedge i_clk) begin
                if (i_dp_cmd.execute) begin
                    if (do_ins && at_pos) begin
                        r_cell_time[gi] <= r_time;
                        r_cell_tag[gi]  <= r_tag;
                        r_cell_hdl[gi]  <= free_hdl;
                    end else if (do_ins && !gt[gi]) begin
                        r_cell_time[gi] <= p_time;
                        r_cell_tag[gi]  <= p_tag;
                        r_cell_hdl[gi]  <= p_hdl;
                    end else if ((r_op == CMD_CANCEL && after[gi])
                                 || (r_op == CMD_POLL && due)) begin
                        r_cell_time[gi] <= s_time;
                        r_cell_tag[gi]  <= s_tag;
                        r_cell_hdl[gi]  <= s_hdl;
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_in_use <= '0;
        end else if (i_dp_cmd.execute) begin
            case (r_op)
                CMD_INS_ABS, CMD_INS_REL: begin
                    if (!full) begin
                        r_count            <= r_count + CNT_W'(1);
                        r_in_use[free_hdl] <= 1'b1;
                    end
                end
                CMD_CANCEL: begin
                    if (found) begin
                        r_count            <= r_count - CNT_W'(1);
                        r_in_use[r_handle] <= 1'b0;
                    end
                end
                default: begin
                    if (due) begin
                        r_count                 <= r_count - CNT_W'(1);
                        r_in_use[r_cell_hdl[0]] <= 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.execute) begin
            case (r_op)
                CMD_INS_ABS, CMD_INS_REL: begin
                    r_status     <= full ? STAT_FULL : STAT_INSERTED;
                    r_res_handle <= full ? '0 : free_hdl;
                    r_res_tag    <= '0;
                    r_res_time   <= '0;
                end
                CMD_CANCEL: begin
                    r_status     <= found ? STAT_CANCELLED : STAT_NOT_FOUND;
                    r_res_handle <= '0;
                    r_res_tag    <= '0;
                    r_res_time   <= '0;
                end
                default: begin
                    r_status     <= due ? STAT_FIRED : STAT_NOTHING_DUE;
                    r_res_handle <= due ? r_cell_hdl[0] : '0;
                    r_res_tag    <= due ? r_cell_tag[0] : '0;
                    r_res_time   <= due ? r_cell_time[0] : '0;
                end
            endcase
        end
    end

    assign o_status        = r_status;
    assign o_result_handle = r_res_handle;
    assign o_result_tag    = r_res_tag;
    assign o_fire_time     = r_res_time;

endmodule

>>> hw/rtl/timed_event_queue_unit.sv
// A result beat is offered once its command has passed the EXEC state, where the
// chain is updated and the result registered; accept, chain update and result beat
//   follow in turn, and the shift cell chain settles any command in that one update.
// The next command is taken only once the previous result beat has been taken.
// Reset (i_rst_n low, synchronous) empties the queue and frees all handles;
//   no clearing pass is needed, the unit takes a command right after reset.
`timescale 1ns / 1ps
module timed_event_queue_unit #(
    parameter int DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // command stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] event_time, [62:32] delay, [94:63] now, [110:95] tag,
    // [114:111] handle, [119:115] zero
    input  logic [119:0] s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]   s_axis_tuser,
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [3:0] result_handle, [19:4] result_tag, [51:20] fire_time, [55:52] zero
    output logic [55:0]  m_axis_tdata,
    // [2:0] status
    output logic [2:0]   m_axis_tuser
);
    import teq_pkg::*;

    t_dp_cmd             dp_cmd;
    logic [HANDLE_W-1:0] res_handle;
    logic [TAG_W-1:0]    res_tag;
    logic [TIME_W-1:0]   res_time;

    // Controller: one command in flight, IDLE -> EXEC -> RESP.
    teq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_dp_cmd    (dp_cmd)
    );

    // Datapath: unpack the command beat. The relative-time add is done
    // when the beat is latched, so the chain compare sees a plain time.
    teq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_dp_cmd        (dp_cmd),
        .i_cmd           (s_axis_tuser),
        .i_event_time    (s_axis_tdata[31:0]),
        .i_delay         (s_axis_tdata[62:32]),
        .i_now           (s_axis_tdata[94:63]),
        .i_tag           (s_axis_tdata[110:95]),
        .i_handle        (s_axis_tdata[114:111]),
        .o_status        (m_axis_tuser),
        .o_result_handle (res_handle),
        .o_result_tag    (res_tag),
        .o_fire_time     (res_time)
    );

    assign m_axis_tdata = {4'b0000, res_time, res_tag, res_handle};

endmodule

>>> hw/rtl/teq_checker.sv
// Port-level assertions for the timed event queue, bound to the top level.
`timescale 1ns / 1ps
module teq_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [55:0]  m_axis_tdata,
    input logic [2:0]   m_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready
);
    import teq_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
            && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // one command in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second command taken while one is in flight");

    // no command taken while a result waits
    a_no_accept_on_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("command taken while result pending");

    // only fired and inserted results carry payload
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != STAT_FIRED && m_axis_tuser != STAT_INSERTED
            |-> m_axis_tdata == '0)
        else $error("nonzero payload on a status-only result");

    // an accepted command produces a result once the chain update is done
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
        else $error("result not offered two cycles after command");

endmodule

bind timed_event_queue_unit teq_checker u_teq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
